// ===== design/srtm_pkg.sv =====
// Package for the SPI register transaction master.
// Holds the byte limits, command codes, header bits, phase encoding and the result struct.
// No dependencies.
`default_nettype none

package srtm_pkg;

   localparam int MAX_BYTES   = 6;
   localparam int WRITE_WIDTH = MAX_BYTES * 8;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [7:0] HDR_READ  = 8'h80;
   localparam logic [7:0] HDR_MULTI = 8'h40;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_HEADER = 3'b010,
      PH_DATA   = 3'b100
   } phase_type;

   typedef struct packed {
      logic       mosi_bit;
      logic       gyro_select_n;
      logic       accel_select_n;
      logic       clock_pulse;
      logic       read_valid;
      logic [7:0] read_byte;
      logic [2:0] byte_index;
      logic       transaction_done;
      logic       start_rejected;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/srtm_if.sv =====
// Valid/ready channel interfaces for the SPI register transaction master.
// srtm_req_if carries request items, srtm_rsp_if carries result items.
// Depends on nothing.
`default_nettype none

interface srtm_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic        is_read;
   logic        target_gyro;
   logic [5:0]  reg_address;
   logic [2:0]  byte_count;
   logic [47:0] write_data;
   logic        miso_bit;

   modport source (output valid, command, is_read, target_gyro, reg_address,
                   byte_count, write_data, miso_bit, input ready);
   modport sink   (input valid, command, is_read, target_gyro, reg_address,
                   byte_count, write_data, miso_bit, output ready);
endinterface

interface srtm_rsp_if;
   logic       valid;
   logic       ready;
   logic       mosi_bit;
   logic       gyro_select_n;
   logic       accel_select_n;
   logic       clock_pulse;
   logic       read_valid;
   logic [7:0] read_byte;
   logic [2:0] byte_index;
   logic       transaction_done;
   logic       start_rejected;

   modport source (output valid, mosi_bit, gyro_select_n, accel_select_n, clock_pulse,
                   read_valid, read_byte, byte_index, transaction_done,
                   start_rejected, input ready);
   modport sink   (input valid, mosi_bit, gyro_select_n, accel_select_n, clock_pulse,
                   read_valid, read_byte, byte_index, transaction_done,
                   start_rejected, output ready);
endinterface

`default_nettype wire

// ===== design/spi_register_transaction_master.sv =====
// SPI register transaction master (mode 3, MSB first, two chip selects).
// The result of an accepted request item goes to the output register, or to the skid entry while the output is held.
// Throughput: one item per cycle while ready is high; the state update is a single pass of shift logic.
// An output register plus one skid entry decouple the sides; ready drops only
// while the skid entry is full. Synchronous active-high reset puts the bus idle,
// both selects released and the data line low, with no result pending.
// Depends on srtm_pkg and srtm_if.
`default_nettype none

module spi_register_transaction_master (
   input  wire logic        clock,
   input  wire logic        reset,
   srtm_req_if.sink         req_channel,
   srtm_rsp_if.source       rsp_channel
);

   srtm_pkg::phase_type                 phase_ff, phase_in;
   logic [2:0]                          bit_counter_ff, bit_counter_in;
   logic [2:0]                          byte_counter_ff, byte_counter_in;
   logic [7:0]                          out_shift_ff, out_shift_in;
   logic [7:0]                          in_shift_ff, in_shift_in;
   logic [srtm_pkg::WRITE_WIDTH-1:0]    pending_ff, pending_in;
   logic                                read_mode_ff, read_mode_in;
   logic                                gyro_target_ff, gyro_target_in;
   logic [2:0]                          total_bytes_ff, total_bytes_in;
   logic                                line_level_ff, line_level_in;

   srtm_pkg::rsp_type                   result;
   srtm_pkg::rsp_type                   out_ff, out_in;
   srtm_pkg::rsp_type                   skid_ff, skid_in;
   logic                                out_valid_ff, out_valid_in;
   logic                                skid_valid_ff, skid_valid_in;

   logic                                accept;
   logic [2:0]                          count_sat;
   logic [2:0]                          byte_next;
   logic [7:0]                          shifted_in;

   assign req_channel.ready = !skid_valid_ff;
   assign accept            = req_channel.valid && req_channel.ready;

   always_comb begin
      phase_in        = phase_ff;
      bit_counter_in  = bit_counter_ff;
      byte_counter_in = byte_counter_ff;
      out_shift_in    = out_shift_ff;
      in_shift_in     = in_shift_ff;
      pending_in      = pending_ff;
      read_mode_in    = read_mode_ff;
      gyro_target_in  = gyro_target_ff;
      total_bytes_in  = total_bytes_ff;
      line_level_in   = line_level_ff;
      result          = '0;
      byte_next       = byte_counter_ff + 3'd1;
      shifted_in      = {in_shift_ff[6:0], req_channel.miso_bit};

      if (req_channel.byte_count == 3'd0) begin
         count_sat = 3'd1;
      end else if (req_channel.byte_count > 3'(srtm_pkg::MAX_BYTES)) begin
         count_sat = 3'(srtm_pkg::MAX_BYTES);
      end else begin
         count_sat = req_channel.byte_count;
      end

      if (accept) begin
         if (req_channel.command == srtm_pkg::CMD_START) begin
            if (phase_ff != srtm_pkg::PH_IDLE) begin
               result.start_rejected = 1'b1;
            end else begin
               read_mode_in    = req_channel.is_read;
               gyro_target_in  = req_channel.target_gyro;
               pending_in      = req_channel.write_data;
               total_bytes_in  = count_sat;
               out_shift_in    = {2'b00, req_channel.reg_address}
                               | (req_channel.is_read ? srtm_pkg::HDR_READ : 8'h00)
                               | ((count_sat > 3'd1) ? srtm_pkg::HDR_MULTI : 8'h00);
               in_shift_in     = '0;
               bit_counter_in  = '0;
               byte_counter_in = '0;
               phase_in        = srtm_pkg::PH_HEADER;
            end
         end else begin
            unique case (phase_ff)
               srtm_pkg::PH_IDLE: begin
                  // idle tick: nothing moves
               end
               srtm_pkg::PH_HEADER: begin
                  result.clock_pulse = 1'b1;
                  line_level_in      = out_shift_ff[7];
                  out_shift_in       = {out_shift_ff[6:0], 1'b0};
                  if (bit_counter_ff == 3'd7) begin
                     bit_counter_in = '0;
                     phase_in       = srtm_pkg::PH_DATA;
                     if (read_mode_ff) begin
                        line_level_in = 1'b1;
                        in_shift_in   = '0;
                     end else begin
                        out_shift_in = pending_ff[7:0];
                        pending_in   = {8'h00, pending_ff[srtm_pkg::WRITE_WIDTH-1:8]};
                     end
                  end else begin
                     bit_counter_in = bit_counter_ff + 3'd1;
                  end
               end
               srtm_pkg::PH_DATA: begin
                  result.clock_pulse = 1'b1;
                  if (read_mode_ff) begin
                     line_level_in = 1'b1;
                     in_shift_in   = shifted_in;
                  end else begin
                     line_level_in = out_shift_ff[7];
                     out_shift_in  = {out_shift_ff[6:0], 1'b0};
                  end
                  if (bit_counter_ff == 3'd7) begin
                     bit_counter_in = '0;
                     if (read_mode_ff) begin
                        result.read_valid = 1'b1;
                        result.read_byte  = shifted_in;
                        result.byte_index = byte_counter_ff;
                        in_shift_in       = '0;
                     end
                     byte_counter_in = byte_next;
                     // a wrapped counter also ends the transaction
                     if (byte_next >= total_bytes_ff || byte_next == 3'd0) begin
                        result.transaction_done = 1'b1;
                        phase_in                = srtm_pkg::PH_IDLE;
                     end else if (!read_mode_ff) begin
                        out_shift_in = pending_ff[7:0];
                        pending_in   = {8'h00, pending_ff[srtm_pkg::WRITE_WIDTH-1:8]};
                     end
                  end else begin
                     bit_counter_in = bit_counter_ff + 3'd1;
                  end
               end
               default: begin
                  phase_in = srtm_pkg::PH_IDLE;
               end
            endcase
         end
      end

      result.mosi_bit       = line_level_in;
      result.gyro_select_n  = !((phase_in != srtm_pkg::PH_IDLE) && gyro_target_in);
      result.accel_select_n = !((phase_in != srtm_pkg::PH_IDLE) && !gyro_target_in);
   end

   // output register with one skid entry behind it
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_channel.ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= srtm_pkg::PH_IDLE;
         bit_counter_ff  <= '0;
         byte_counter_ff <= '0;
         out_shift_ff    <= '0;
         in_shift_ff     <= '0;
         pending_ff      <= '0;
         read_mode_ff    <= 1'b0;
         gyro_target_ff  <= 1'b0;
         total_bytes_ff  <= '0;
         line_level_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         bit_counter_ff  <= bit_counter_in;
         byte_counter_ff <= byte_counter_in;
         out_shift_ff    <= out_shift_in;
         in_shift_ff     <= in_shift_in;
         pending_ff      <= pending_in;
         read_mode_ff    <= read_mode_in;
         gyro_target_ff  <= gyro_target_in;
         total_bytes_ff  <= total_bytes_in;
         line_level_ff   <= line_level_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_channel.valid            = out_valid_ff;
   assign rsp_channel.mosi_bit         = out_ff.mosi_bit;
   assign rsp_channel.gyro_select_n    = out_ff.gyro_select_n;
   assign rsp_channel.accel_select_n   = out_ff.accel_select_n;
   assign rsp_channel.clock_pulse      = out_ff.clock_pulse;
   assign rsp_channel.read_valid       = out_ff.read_valid;
   assign rsp_channel.read_byte        = out_ff.read_byte;
   assign rsp_channel.byte_index       = out_ff.byte_index;
   assign rsp_channel.transaction_done = out_ff.transaction_done;
   assign rsp_channel.start_rejected   = out_ff.start_rejected;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output register empty");

   a_one_select: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.gyro_select_n || out_ff.accel_select_n))
      else $error("both chip selects asserted");

   a_idle_counter: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == srtm_pkg::PH_IDLE) |-> (bit_counter_ff == 3'd0))
      else $error("bit counter nonzero while idle");

   a_done_clocks: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.transaction_done || out_ff.read_valid))
      |-> out_ff.clock_pulse)
      else $error("byte completion without a clock pulse");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && result.transaction_done) |=> (phase_ff == srtm_pkg::PH_IDLE))
      else $error("transaction done but bus still busy");

endmodule

`default_nettype wire
